[sv/stlm_pkg.sv]
package stlm_pkg;

    // Entries in each list store
    localparam int LIST_DEPTH = 1024;
    // Address bits for one store entry
    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    // Count and head bits, wide enough to hold LIST_DEPTH itself
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    // Element width
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_PUSH_A = 2'd1,
        CMD_PUSH_B = 2'd2,
        CMD_POP    = 2'd3
    } cmd_t;

endpackage

[sv/stlm_ram.sv]
module stlm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/sorted_two_list_merge.sv]
// Merge of two ascending lists of signed 32-bit values.
// Input channel (in_valid / in_stall, command and value): a transfer pushes
// value onto list A or list B, clears both lists, or pops the next element
// of the merged order. Only a pop yields a result.
// Output channel (out_valid / out_stall): one transfer per pop with
// merged_value, last_element, exhausted and the sticky overflow flag as it
// stood at the pop.
// Push and clear may follow back to back. A pop passes two states: its
// transfer in ST_IDLE issues reads of both list heads to the two
// single-port-read stores; ST_READ, which stalls the input, compares the
// returned heads, advances one head pointer and loads the output register.
// A push to a full list is dropped and sets overflow, which holds until
// reset; clear does not reset it.
// When the receiver stalls, the result waits in the output register;
// pushes and clears keep being taken, a following pop waits in its read
// cycle until the output register frees up.
// Reset empties both lists and clears overflow; store contents are not
// touched, and a value read before it is written is never used.
module sorted_two_list_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  merged_value,
    output logic                last_element,
    output logic                exhausted,
    output logic                overflow
);

    localparam int CW = stlm_pkg::CNT_W;
    localparam int AW = stlm_pkg::ADDR_W;
    localparam int DW = stlm_pkg::DATA_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(stlm_pkg::LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_a_reg, count_a_next;
    logic [CW-1:0]  count_b_reg, count_b_next;
    logic [CW-1:0]  head_a_reg, head_a_next;
    logic [CW-1:0]  head_b_reg, head_b_next;
    logic           ovf_reg, ovf_next;
    logic           a_left_reg, a_left_next;
    logic           b_left_reg, b_left_next;
    logic           out_valid_reg, out_valid_next;
    logic [DW-1:0]  merged_reg, merged_next;
    logic           last_reg, last_next;
    logic           exh_reg, exh_next;
    logic           ovf_out_reg, ovf_out_next;

    logic           in_xfer;
    logic           out_free;
    stlm_pkg::cmd_t cmd;
    logic           we_a, we_b, re;
    logic [DW-1:0]  rdata_a, rdata_b;
    logic           take_a;
    logic [CW-1:0]  head_a_inc, head_b_inc;

    assign cmd      = stlm_pkg::cmd_t'(command);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Store writes at the tail, head reads on a pop transfer
    assign we_a = in_xfer && (cmd == stlm_pkg::CMD_PUSH_A) && (count_a_reg < DEPTH_C);
    assign we_b = in_xfer && (cmd == stlm_pkg::CMD_PUSH_B) && (count_b_reg < DEPTH_C);
    assign re   = in_xfer && (cmd == stlm_pkg::CMD_POP);

    stlm_ram #(
        .WIDTH (DW),
        .DEPTH (stlm_pkg::LIST_DEPTH),
        .ADDR_W(AW)
    ) u_store_a (
        .clk  (clk),
        .we   (we_a),
        .waddr(count_a_reg[AW-1:0]),
        .wdata(value),
        .re   (re),
        .raddr(head_a_reg[AW-1:0]),
        .rdata(rdata_a)
    );

    stlm_ram #(
        .WIDTH (DW),
        .DEPTH (stlm_pkg::LIST_DEPTH),
        .ADDR_W(AW)
    ) u_store_b (
        .clk  (clk),
        .we   (we_b),
        .waddr(count_b_reg[AW-1:0]),
        .wdata(value),
        .re   (re),
        .raddr(head_b_reg[AW-1:0]),
        .rdata(rdata_b)
    );

    // Pick list A unless only B is left or B's head is smaller
    assign take_a = a_left_reg &&
                    (!b_left_reg || !($signed(rdata_a) > $signed(rdata_b)));
    assign head_a_inc = head_a_reg + ONE_C;
    assign head_b_inc = head_b_reg + ONE_C;

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        head_a_next    = head_a_reg;
        head_b_next    = head_b_reg;
        ovf_next       = ovf_reg;
        a_left_next    = a_left_reg;
        b_left_next    = b_left_reg;
        out_valid_next = out_valid_reg;
        merged_next    = merged_reg;
        last_next      = last_reg;
        exh_next       = exh_reg;
        ovf_out_next   = ovf_out_reg;

        // Drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (cmd)
                        stlm_pkg::CMD_CLEAR:
                        begin
                            count_a_next = '0;
                            count_b_next = '0;
                            head_a_next  = '0;
                            head_b_next  = '0;
                        end
                        stlm_pkg::CMD_PUSH_A:
                        begin
                            if (we_a)
                            begin
                                count_a_next = count_a_reg + ONE_C;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        stlm_pkg::CMD_PUSH_B:
                        begin
                            if (we_b)
                            begin
                                count_b_next = count_b_reg + ONE_C;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        stlm_pkg::CMD_POP:
                        begin
                            a_left_next = (head_a_reg < count_a_reg);
                            b_left_next = (head_b_reg < count_b_reg);
                            state_next  = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    ovf_out_next   = ovf_reg;
                    if (!a_left_reg && !b_left_reg)
                    begin
                        merged_next = '0;
                        last_next   = 1'b0;
                        exh_next    = 1'b1;
                    end
                    else if (take_a)
                    begin
                        merged_next = rdata_a;
                        head_a_next = head_a_inc;
                        last_next   = (head_a_inc >= count_a_reg) && !b_left_reg;
                        exh_next    = 1'b0;
                    end
                    else
                    begin
                        merged_next = rdata_b;
                        head_b_next = head_b_inc;
                        last_next   = (head_b_inc >= count_b_reg) && !a_left_reg;
                        exh_next    = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            head_a_reg    <= '0;
            head_b_reg    <= '0;
            ovf_reg       <= 1'b0;
            a_left_reg    <= 1'b0;
            b_left_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            head_a_reg    <= head_a_next;
            head_b_reg    <= head_b_next;
            ovf_reg       <= ovf_next;
            a_left_reg    <= a_left_next;
            b_left_reg    <= b_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        merged_reg  <= merged_next;
        last_reg    <= last_next;
        exh_reg     <= exh_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = $signed(merged_reg);
    assign last_element = last_reg;
    assign exhausted    = exh_reg;
    assign overflow     = ovf_out_reg;

endmodule

[verif/merge_result_checker.sv]
`timescale 1ns / 100ps

module merge_result_checker
    import stlm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               command,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DATA_W-1:0] merged_value,
    input  logic                     last_element,
    input  logic                     exhausted,
    input  logic                     overflow,
    output int                       fails,
    output int                       pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] elem;
        logic                     last;
        logic                     empty;
        logic                     sticky;
    } merge_out_t;

    // Shadow copy of both lists and their pointers
    logic signed [DATA_W-1:0] list_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] list_b [LIST_DEPTH];
    int unsigned              len_a;
    int unsigned              len_b;
    int unsigned              next_a;
    int unsigned              next_b;
    logic                     dropped;

    merge_out_t merges_due [$];
    merge_out_t want;
    int         fail_count = 0;

    assign fails = fail_count;

    // Apply one command to the shadow lists; a pop queues the merged element
    task automatic take_command(input cmd_t cmd, input logic signed [DATA_W-1:0] v);
        merge_out_t r;
        logic       a_left;
        logic       b_left;
        r = '0;
        case (cmd)
            CMD_CLEAR:
            begin
                len_a  = 0;
                len_b  = 0;
                next_a = 0;
                next_b = 0;
            end
            CMD_PUSH_A:
            begin
                if (len_a >= LIST_DEPTH)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    list_a[len_a] = v;
                    len_a++;
                end
            end
            CMD_PUSH_B:
            begin
                if (len_b >= LIST_DEPTH)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    list_b[len_b] = v;
                    len_b++;
                end
            end
            CMD_POP:
            begin
                a_left = next_a < len_a;
                b_left = next_b < len_b;
                // A wins a tie
                if (a_left && (!b_left || list_a[next_a] <= list_b[next_b]))
                begin
                    r.elem = list_a[next_a];
                    next_a++;
                end
                else if (b_left)
                begin
                    r.elem = list_b[next_b];
                    next_b++;
                end
                else
                begin
                    r.empty = 1'b1;
                end
                r.last   = !r.empty && next_a >= len_a && next_b >= len_b;
                r.sticky = dropped;
                merges_due.push_back(r);
            end
        endcase
    endtask

    task automatic report(input string field, input longint exp_val, input longint act_val);
        $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
        fail_count++;
    endtask

    // Compare each result transfer with the oldest pop, then track the input transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a   = 0;
            len_b   = 0;
            next_a  = 0;
            next_b  = 0;
            dropped = 1'b0;
            merges_due.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (merges_due.size() == 0)
                begin
                    $display("%0t: result with no pop waiting, merged_value %0d",
                             $time, merged_value);
                    fail_count++;
                end
                else
                begin
                    want = merges_due.pop_front();
                    if (want.elem !== merged_value)
                        report("merged_value", want.elem, merged_value);
                    if (want.last !== last_element)
                        report("last_element", want.last, last_element);
                    if (want.empty !== exhausted)
                        report("exhausted", want.empty, exhausted);
                    if (want.sticky !== overflow)
                        report("overflow", want.sticky, overflow);
                end
            end
            if (in_valid && !in_stall)
                take_command(cmd_t'(command), value);
            pending <= merges_due.size();
        end
    end

endmodule

[verif/sorted_two_list_merge_tb.sv]
`timescale 1ns / 100ps

module sorted_two_list_merge_tb;
    import stlm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [1:0]               command   = CMD_CLEAR;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [DATA_W-1:0] merged_value;
    logic                     last_element;
    logic                     exhausted;
    logic                     overflow;

    int   fails;
    int   pending;
    int   cycles   = 0;
    int   sent     = 0;
    int   rx_count = 0;
    int   rx_hold  = 0;
    int   rx_draw  = 0;
    logic tx_calm  = 1'b0;
    logic rx_calm  = 1'b0;

    always #6 clk = ~clk;

    sorted_two_list_merge DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .merged_value (merged_value),
        .last_element (last_element),
        .exhausted    (exhausted),
        .overflow     (overflow)
    );

    merge_result_checker u_merge_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .merged_value (merged_value),
        .last_element (last_element),
        .exhausted    (exhausted),
        .overflow     (overflow),
        .fails        (fails),
        .pending      (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stall the result channel for a random count after each transfer,
    // now and then also while idle; calm stretches stall never
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            rx_draw = rx_hold;
            if (out_valid && !out_stall)
            begin
                rx_count++;
                if (rx_count % 32 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_draw = rx_calm ? 0 : $urandom_range(0, 15);
            end
            else if (!rx_calm && rx_draw == 0 && $urandom_range(0, 7) == 0)
            begin
                rx_draw = $urandom_range(1, 15);
            end
            if (rx_draw > 0)
            begin
                out_stall <= 1'b1;
                rx_hold = rx_draw - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                rx_hold = 0;
            end
        end
    end

    // Idle a random count, then hold one command until it transfers
    task automatic send(input cmd_t c, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        if (sent % 40 == 0)
            tx_calm = ($urandom_range(0, 2) == 0);
    endtask

    // Next value of an ascending list: repeat, small, medium or wide step
    function automatic logic signed [DATA_W-1:0] climb(input logic signed [DATA_W-1:0] prev);
        longint nv;
        case ($urandom_range(0, 3))
            0:       nv = prev;
            1:       nv = longint'(prev) + longint'($urandom_range(1, 16));
            2:       nv = longint'(prev) + longint'($urandom_range(1, 1 << 20));
            default: nv = longint'(prev) + longint'($urandom);
        endcase
        if (nv > 64'sh7FFF_FFFF)
            nv = 64'sh7FFF_FFFF;
        return nv[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] fresh();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return -$signed($urandom_range(0, 1000));
            default: return $signed($urandom);
        endcase
    endfunction

    // Clear, fill both lists in order (some pops mixed in), then drain them
    task automatic merge_round();
        int                       want_a;
        int                       want_b;
        int                       have_a;
        int                       have_b;
        int                       pops;
        int                       drain;
        logic signed [DATA_W-1:0] top_a;
        logic signed [DATA_W-1:0] top_b;
        logic signed [DATA_W-1:0] v;
        send(CMD_CLEAR, $signed($urandom));
        want_a = $urandom_range(0, 12);
        want_b = $urandom_range(0, 12);
        have_a = 0;
        have_b = 0;
        pops   = 0;
        top_a  = '0;
        top_b  = '0;
        while (have_a < want_a || have_b < want_b)
        begin
            if (have_a < want_a && (have_b >= want_b || $urandom_range(0, 1) == 1))
            begin
                if (have_b > 0 && (have_a == 0 || top_b >= top_a) && $urandom_range(0, 3) == 0)
                    v = top_b;
                else if (have_a == 0)
                    v = fresh();
                else
                    v = climb(top_a);
                send(CMD_PUSH_A, v);
                top_a = v;
                have_a++;
            end
            else
            begin
                if (have_a > 0 && (have_b == 0 || top_a >= top_b) && $urandom_range(0, 3) == 0)
                    v = top_a;
                else if (have_b == 0)
                    v = fresh();
                else
                    v = climb(top_b);
                send(CMD_PUSH_B, v);
                top_b = v;
                have_b++;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                send(CMD_POP, $signed($urandom));
                pops++;
            end
        end
        drain = want_a + want_b - pops;
        if (drain < 0)
            drain = 0;
        repeat (drain + $urandom_range(0, 2)) send(CMD_POP, $signed($urandom));
    endtask

    // Unordered commands with random values
    task automatic noise_burst();
        repeat ($urandom_range(1, 10)) send(cmd_t'($urandom_range(0, 3)), $signed($urandom));
    endtask

    // Fill list A past its depth so pushes drop and the sticky flag sets
    task automatic overflow_phase();
        logic signed [DATA_W-1:0] v;
        v = -$signed($urandom_range(0, 1 << 24));
        send(CMD_CLEAR, '0);
        repeat (LIST_DEPTH + 2)
        begin
            v = v + $signed($urandom_range(0, 3));
            send(CMD_PUSH_A, v);
        end
        repeat (3) send(CMD_PUSH_B, $signed($urandom));
        repeat (12) send(CMD_POP, '0);
        send(CMD_CLEAR, '0);
        send(CMD_POP, '0);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, ties at both extremes, push after pops, clear
        send(CMD_POP, 32'sh7FFF_FFFF);
        send(CMD_PUSH_A, 32'sh8000_0000);
        send(CMD_PUSH_B, 32'sh8000_0000);
        send(CMD_PUSH_A, -32'sd5);
        send(CMD_PUSH_B, 32'sd7);
        send(CMD_PUSH_A, 32'sd7);
        send(CMD_PUSH_B, 32'sh7FFF_FFFF);
        send(CMD_PUSH_A, 32'sh7FFF_FFFF);
        repeat (8) send(CMD_POP, '0);
        send(CMD_PUSH_B, 32'sd3);
        send(CMD_POP, -32'sd1);
        send(CMD_PUSH_A, 32'sd1);
        send(CMD_CLEAR, -32'sd1);
        send(CMD_POP, '0);

        // Random rounds, mostly well-formed
        while (sent < 420)
        begin
            if ($urandom_range(0, 9) == 0)
                noise_burst();
            else
                merge_round();
        end

        overflow_phase();
        repeat (8) merge_round();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
